// ===== hw/rtl/dpvw_pkg.sv =====
// Shared types and constants for the delta patch video memory write decoder.
`timescale 1ns / 1ps

package dpvw_pkg;

  localparam logic [7:0] PAGE_LOW  = 8'd9;
  localparam logic [7:0] PAGE_HIGH = 8'd10;
  localparam logic [7:0] PAGE_NONE = 8'd255;
  localparam logic [7:0] PAGE_CMD  = 8'd142;
  localparam int unsigned PAGE_BIT = 6;
  localparam int unsigned HIGH_W   = 6;
  localparam logic [1:0] HIGH_SET  = 2'b01;

  typedef enum logic [1:0] {
    CMD_END  = 2'd0,
    CMD_HDR  = 2'd1,
    CMD_DATA = 2'd2
  } cmd_kind_e;

  // One parsed command from the front to the back.
  typedef struct packed {
    cmd_kind_e         kind;
    logic              send_page;
    logic              page_hi;
    logic [7:0]        lo;
    logic [HIGH_W-1:0] hi;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } cmd_push_t;

  typedef struct packed {
    logic empty;
    cmd_t head;
  } cmd_head_t;

endpackage

// ===== hw/rtl/delta_patch_vram_write_decoder.sv =====
// Top level of the delta patch video memory write decoder.
`timescale 1ns / 1ps

// Takes one stream word per cycle whenever the command queue has room
// (FifoDepth entries). Count and low address words produce nothing; a high
// address word produces two or four control writes, a data word one data
// write, and a zero count word one end-marker word. The back end emits one
// port write per cycle unless out_stall_i holds it, so a header high word
// occupies the output for its two or four writes while the front keeps
// accepting words into the queue. An accepted word passes through the queue
// and then the output register before its first write.
module delta_patch_vram_write_decoder
  import dpvw_pkg::*;
#(
  parameter int unsigned FifoDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] stream_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       to_control_o,
  output logic [7:0] port_value_o,
  output logic       last_of_run_o,
  output logic       stream_end_o
);

  cmd_push_t push;
  cmd_head_t head;
  logic      q_full;
  logic      pop;

  dpvw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .stream_byte_i (stream_byte_i),
    .q_full_i      (q_full),
    .push_o        (push)
  );

  dpvw_queue #(
    .Depth (FifoDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (q_full),
    .head_o (head)
  );

  dpvw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .to_control_o  (to_control_o),
    .port_value_o  (port_value_o),
    .last_of_run_o (last_of_run_o),
    .stream_end_o  (stream_end_o)
  );

endmodule

// ===== hw/rtl/dpvw_front.sv =====
// Front end: parses stream words and pushes write commands into the queue.
`timescale 1ns / 1ps

module dpvw_front
  import dpvw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] stream_byte_i,
  input  logic       q_full_i,
  output cmd_push_t  push_o
);

  typedef enum logic [1:0] {
    PH_COUNT = 2'd0,
    PH_LOW   = 2'd1,
    PH_HIGH  = 2'd2,
    PH_DATA  = 2'd3
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] bytes_left_q, bytes_left_d;
  logic [7:0] addr_low_q, addr_low_d;
  logic [7:0] page_sent_q, page_sent_d;
  logic [7:0] page;
  logic       accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign page       = stream_byte_i[PAGE_BIT] ? PAGE_HIGH : PAGE_LOW;

  always_comb begin
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    addr_low_d   = addr_low_q;
    page_sent_d  = page_sent_q;
    push_o       = '0;
    push_o.cmd.kind = CMD_END;
    if (accept) begin
      unique case (phase_q)
        PH_COUNT: begin
          if (stream_byte_i == 8'd0) begin
            push_o.push     = 1'b1;
            push_o.cmd.kind = CMD_END;
            page_sent_d     = PAGE_NONE;
            bytes_left_d    = 8'd0;
          end else begin
            bytes_left_d = stream_byte_i;
            phase_d      = PH_LOW;
          end
        end
        PH_LOW: begin
          addr_low_d = stream_byte_i;
          phase_d    = PH_HIGH;
        end
        PH_HIGH: begin
          push_o.push          = 1'b1;
          push_o.cmd.kind      = CMD_HDR;
          push_o.cmd.send_page = (page != page_sent_q);
          push_o.cmd.page_hi   = stream_byte_i[PAGE_BIT];
          push_o.cmd.lo        = addr_low_q;
          push_o.cmd.hi        = stream_byte_i[HIGH_W-1:0];
          page_sent_d          = page;
          phase_d              = PH_DATA;
        end
        PH_DATA: begin
          push_o.push     = 1'b1;
          push_o.cmd.kind = CMD_DATA;
          push_o.cmd.lo   = stream_byte_i;
          bytes_left_d    = bytes_left_q - 8'd1;
          if (bytes_left_d == 8'd0) begin
            phase_d = PH_COUNT;
          end
        end
        default: phase_d = PH_COUNT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_COUNT;
      bytes_left_q <= 8'd0;
      addr_low_q   <= 8'd0;
      page_sent_q  <= PAGE_NONE;
    end else begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      addr_low_q   <= addr_low_d;
      page_sent_q  <= page_sent_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_push_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.push |-> (in_valid_i && !q_full_i))
    else $error("command pushed without an accepted word");
`endif

endmodule

// ===== hw/rtl/dpvw_queue.sv =====
// Short register queue of parsed commands between front and back.
`timescale 1ns / 1ps

module dpvw_queue
  import dpvw_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_push_t push_i,
  input  logic      pop_i,
  output logic      full_o,
  output cmd_head_t head_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  cmd_t             entry_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o       = (count_q == FullCnt);
  assign head_o.empty = (count_q == '0);
  assign head_o.head  = entry_q[rd_ptr_q];
  assign do_push      = push_i.push && !full_o;
  assign do_pop       = pop_i && !head_o.empty;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_i.cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i.push && full_o))
    else $error("push into a full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && head_o.empty))
    else $error("pop from an empty queue");
`endif

endmodule

// ===== hw/rtl/dpvw_back.sv =====
// Back end: expands queued commands into port writes, one word per cycle while the output is not stalled.
`timescale 1ns / 1ps

module dpvw_back
  import dpvw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_head_t  head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       to_control_o,
  output logic [7:0] port_value_o,
  output logic       last_of_run_o,
  output logic       stream_end_o
);

  logic       out_valid_q;
  logic [1:0] step_q;
  logic       load, fire;
  logic [1:0] idx;
  logic       w_ctl, w_last, w_end;
  logic [7:0] w_val;
  logic       ctl_q, last_q, end_q;
  logic [7:0] val_q;

  assign load = !out_valid_q || !out_stall_i;
  assign fire = load && !head_i.empty;
  assign idx  = head_i.head.send_page ? step_q : step_q + 2'd2;

  // Header order: page, page command, low address, high address.
  always_comb begin
    w_ctl  = 1'b0;
    w_val  = 8'd0;
    w_last = 1'b1;
    w_end  = 1'b0;
    unique case (head_i.head.kind)
      CMD_END: begin
        w_end = 1'b1;
      end
      CMD_DATA: begin
        w_val = head_i.head.lo;
      end
      CMD_HDR: begin
        w_ctl  = 1'b1;
        w_last = (idx == 2'd3);
        unique case (idx)
          2'd0:    w_val = head_i.head.page_hi ? PAGE_HIGH : PAGE_LOW;
          2'd1:    w_val = PAGE_CMD;
          2'd2:    w_val = head_i.head.lo;
          default: w_val = {HIGH_SET, head_i.head.hi};
        endcase
      end
      default: w_end = 1'b0;
    endcase
  end

  assign pop_o = fire && w_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= 2'd0;
    end else begin
      if (load) begin
        out_valid_q <= fire;
      end
      if (fire) begin
        step_q <= w_last ? 2'd0 : step_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      ctl_q  <= w_ctl;
      val_q  <= w_val;
      last_q <= w_last;
      end_q  <= w_end;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign to_control_o  = ctl_q;
  assign port_value_o  = val_q;
  assign last_of_run_o = last_q;
  assign stream_end_o  = end_q;

`ifndef NO_ASSERTIONS
  a_step_in_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != 2'd0) |-> (!head_i.empty && head_i.head.kind == CMD_HDR))
    else $error("multi-word step outside a header command");
  a_pop_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (out_valid_o && last_of_run_o))
    else $error("command retired without its final word");
`endif

endmodule
